### hdl/hfe_pkg.sv
// Shared types, constants and helpers for the Haar feature evaluator.
`default_nettype none
package hfe_pkg;

    localparam int IMAGE_SIDE   = 24;
    localparam int ADDR_W       = $clog2(IMAGE_SIDE * IMAGE_SIDE);
    localparam int COORD_W      = 7;
    localparam int FIELD_W      = 5;
    localparam int CORNER_W     = 10;
    localparam int WORD_W       = 32;
    localparam int TOTAL_W      = 40;
    localparam int OUT_W        = 36;
    localparam int CFG_W        = 5;
    localparam int CFG_INDEX_W  = 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_CORNERS  = 4;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(24);
    localparam logic [OUT_W-1:0] OVERSIZE_VALUE = OUT_W'(120);

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_HEADER = 2'd1;
    localparam logic [1:0] REQ_RECT   = 2'd2;

    // corner slots inside a queue entry
    localparam int CORNER_A = 0;
    localparam int CORNER_B = 1;
    localparam int CORNER_C = 2;
    localparam int CORNER_D = 3;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_HEADER,
        KIND_RECT
    } kind_t;

    // one classified item travelling from front to back
    typedef struct packed {
        kind_t                                  kind;
        logic [ADDR_W-1:0]                      waddr;
        logic [WORD_W-1:0]                      wdata;
        logic                                   oversize;
        logic [NUM_CORNERS-1:0][ADDR_W-1:0]     addr;
        logic [NUM_CORNERS-1:0]                 ok;
        logic                                   is_black;
        logic                                   last;
    } entry_t;

    function automatic logic [ADDR_W-1:0] store_addr(logic [COORD_W-1:0] y,
                                                     logic [COORD_W-1:0] x);
        return ADDR_W'(y) * ADDR_W'(IMAGE_SIDE) + ADDR_W'(x);
    endfunction

endpackage
`default_nettype wire

### hdl/hfe_queue.sv
// Small FIFO of classified items between front and back.
`default_nettype none
module hfe_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire hfe_pkg::entry_t push_entry,
    output logic                 full,
    input  wire logic            pop,
    output logic                 pop_valid,
    output hfe_pkg::entry_t      pop_entry
);

    hfe_pkg::entry_t                  slot_reg [hfe_pkg::QUEUE_DEPTH];
    logic [hfe_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [hfe_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [hfe_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             do_push, do_pop;

    assign full      = (count_reg == hfe_pkg::QCNT_W'(hfe_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == hfe_pkg::QPTR_W'(hfe_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == hfe_pkg::QPTR_W'(hfe_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

### hdl/hfe_front.sv
// Front end: config registers, item accept, placement and corner address generation.
`default_nettype none
module hfe_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write_en,
    input  wire logic [hfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [hfe_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         req_type,
    input  wire logic [hfe_pkg::FIELD_W-1:0]        pos_x,
    input  wire logic [hfe_pkg::FIELD_W-1:0]        pos_y,
    input  wire logic [hfe_pkg::FIELD_W-1:0]        mask_w,
    input  wire logic [hfe_pkg::FIELD_W-1:0]        mask_h,
    input  wire logic [hfe_pkg::WORD_W-1:0]         word_value,
    input  wire logic                               is_black,
    input  wire logic                               last_rect,
    input  wire logic [hfe_pkg::CORNER_W-1:0]       corner_a,
    input  wire logic [hfe_pkg::CORNER_W-1:0]       corner_b,
    input  wire logic [hfe_pkg::CORNER_W-1:0]       corner_c,
    input  wire logic [hfe_pkg::CORNER_W-1:0]       corner_d,
    input  wire logic                               q_full,
    output logic                                    push,
    output hfe_pkg::entry_t                         push_entry
);

    logic [hfe_pkg::CFG_W-1:0]      image_width_reg, image_width_next;
    logic [hfe_pkg::CFG_W-1:0]      image_height_reg, image_height_next;
    logic [hfe_pkg::FIELD_W-1:0]    place_x_reg, place_x_next;
    logic [hfe_pkg::FIELD_W-1:0]    place_y_reg, place_y_next;
    logic                           accept;
    logic [hfe_pkg::COORD_W-1:0]    width_lim, height_lim;
    logic [hfe_pkg::CORNER_W-1:0]   corner [hfe_pkg::NUM_CORNERS];
    logic [hfe_pkg::NUM_CORNERS-1:0] dec_x, dec_y;
    logic [hfe_pkg::COORD_W-1:0]    cx [hfe_pkg::NUM_CORNERS];
    logic [hfe_pkg::COORD_W-1:0]    cy [hfe_pkg::NUM_CORNERS];

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // A and C step one column left, A and B one row up
    assign dec_x = 4'b0101;
    assign dec_y = 4'b0011;

    assign corner[hfe_pkg::CORNER_A] = corner_a;
    assign corner[hfe_pkg::CORNER_B] = corner_b;
    assign corner[hfe_pkg::CORNER_C] = corner_c;
    assign corner[hfe_pkg::CORNER_D] = corner_d;

    assign width_lim  = (int'(image_width_reg) < hfe_pkg::IMAGE_SIDE) ?
                        hfe_pkg::COORD_W'(image_width_reg) :
                        hfe_pkg::COORD_W'(hfe_pkg::IMAGE_SIDE);
    assign height_lim = (int'(image_height_reg) < hfe_pkg::IMAGE_SIDE) ?
                        hfe_pkg::COORD_W'(image_height_reg) :
                        hfe_pkg::COORD_W'(hfe_pkg::IMAGE_SIDE);

    // a coordinate of -1 wraps to all ones, which always fails the upper bound
    always_comb
    begin
        for (int i = 0; i < hfe_pkg::NUM_CORNERS; i++)
        begin
            cx[i] = hfe_pkg::COORD_W'(corner[i][4:0]) + hfe_pkg::COORD_W'(place_x_reg)
                    - hfe_pkg::COORD_W'(dec_x[i]);
            cy[i] = hfe_pkg::COORD_W'(corner[i][9:5]) + hfe_pkg::COORD_W'(place_y_reg)
                    - hfe_pkg::COORD_W'(dec_y[i]);
        end
    end

    always_comb
    begin
        push_entry          = '0;
        push_entry.kind     = hfe_pkg::KIND_RECT;
        push                = 1'b0;
        case (req_type)
            hfe_pkg::REQ_LOAD:
            begin
                push_entry.kind  = hfe_pkg::KIND_LOAD;
                push_entry.waddr = hfe_pkg::store_addr(hfe_pkg::COORD_W'(pos_y),
                                                       hfe_pkg::COORD_W'(pos_x));
                push_entry.wdata = word_value;
                push = accept && (int'(pos_x) < hfe_pkg::IMAGE_SIDE)
                              && (int'(pos_y) < hfe_pkg::IMAGE_SIDE);
            end
            hfe_pkg::REQ_HEADER:
            begin
                push_entry.kind     = hfe_pkg::KIND_HEADER;
                push_entry.oversize = (mask_w > image_width_reg) ||
                                      (mask_h > image_height_reg);
                push = accept;
            end
            hfe_pkg::REQ_RECT:
            begin
                push_entry.kind     = hfe_pkg::KIND_RECT;
                push_entry.is_black = is_black;
                push_entry.last     = last_rect;
                for (int i = 0; i < hfe_pkg::NUM_CORNERS; i++)
                begin
                    push_entry.ok[i]   = (cx[i] < width_lim) && (cy[i] < height_lim);
                    push_entry.addr[i] = hfe_pkg::store_addr(cy[i], cx[i]);
                end
                push = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        place_x_next      = place_x_reg;
        place_y_next      = place_y_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                hfe_pkg::REG_IMAGE_WIDTH:  image_width_next  = cfg_data;
                hfe_pkg::REG_IMAGE_HEIGHT: image_height_next = cfg_data;
                default: ;
            endcase
        end
        if (accept && (req_type == hfe_pkg::REQ_HEADER))
        begin
            place_x_next = pos_x;
            place_y_next = pos_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= hfe_pkg::DIM_RESET;
            image_height_reg <= hfe_pkg::DIM_RESET;
            place_x_reg      <= '0;
            place_y_reg      <= '0;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            place_x_reg      <= place_x_next;
            place_y_reg      <= place_y_next;
        end
    end

endmodule
`default_nettype wire

### hdl/hfe_back.sv
// Back end: integral store, corner reads, black/white totals and result register.
`default_nettype none
module hfe_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    input  wire hfe_pkg::entry_t                q_entry,
    output logic                                q_pop,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [hfe_pkg::OUT_W-1:0]           filter_value,
    output logic                                mask_too_large
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SECOND = 3'b010,
        ST_ACC    = 3'b100
    } state_t;

    localparam int DEPTH = hfe_pkg::IMAGE_SIDE * hfe_pkg::IMAGE_SIDE;

    logic [hfe_pkg::WORD_W-1:0]     mem [DEPTH];

    state_t                         state_reg, state_next;
    hfe_pkg::entry_t                rect_reg;
    logic [hfe_pkg::ADDR_W-1:0]     raddr0_reg, raddr1_reg;
    logic [hfe_pkg::ADDR_W-1:0]     raddr0, raddr1;
    logic [hfe_pkg::WORD_W-1:0]     rdata0_reg, rdata1_reg;
    logic [hfe_pkg::WORD_W:0]       pos_sum_reg;
    logic                           oversize_flag_reg, oversize_flag_next;
    logic [hfe_pkg::TOTAL_W-1:0]    black_total_reg, black_total_next;
    logic [hfe_pkg::TOTAL_W-1:0]    white_total_reg, white_total_next;
    logic                           fin_valid_reg, fin_valid_next;
    logic [hfe_pkg::TOTAL_W-1:0]    fin_black_reg, fin_white_reg;
    logic                           fin_oversize_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [hfe_pkg::OUT_W-1:0]      filter_value_reg;
    logic                           mask_too_large_reg;

    logic                           fin_drain, acc_go, can_pop, issue;
    logic                           pop_load, pop_header, pop_rect, in_second, acc_update;
    logic [hfe_pkg::WORD_W-1:0]     word_a, word_d, word_b, word_c;
    logic [hfe_pkg::TOTAL_W-1:0]    rect_val, black_upd, white_upd;
    logic [hfe_pkg::TOTAL_W:0]      mag;
    logic [hfe_pkg::OUT_W-1:0]      result_value;

    assign out_valid      = out_valid_reg;
    assign filter_value   = filter_value_reg;
    assign mask_too_large = mask_too_large_reg;

    assign fin_drain = fin_valid_reg && (!out_valid_reg || !out_stall);
    // a last rectangle waits in ACC until the result stage has room
    assign acc_go    = !rect_reg.last || !fin_valid_reg || fin_drain;
    assign can_pop   = (state_reg == ST_IDLE) || ((state_reg == ST_ACC) && acc_go);
    assign q_pop     = can_pop && q_valid;

    assign pop_load   = q_pop && (q_entry.kind == hfe_pkg::KIND_LOAD);
    assign pop_header = q_pop && (q_entry.kind == hfe_pkg::KIND_HEADER);
    assign pop_rect   = q_pop && (q_entry.kind == hfe_pkg::KIND_RECT);
    assign in_second  = (state_reg == ST_SECOND);
    assign acc_update = (state_reg == ST_ACC) && acc_go;

    // port 0 reads A then B, port 1 reads D then C; address holds between reads
    assign issue  = pop_rect || in_second;
    assign raddr0 = pop_rect  ? q_entry.addr[hfe_pkg::CORNER_A] :
                    in_second ? rect_reg.addr[hfe_pkg::CORNER_B] : raddr0_reg;
    assign raddr1 = pop_rect  ? q_entry.addr[hfe_pkg::CORNER_D] :
                    in_second ? rect_reg.addr[hfe_pkg::CORNER_C] : raddr1_reg;

    always_ff @(posedge clk)
    begin
        if (pop_load)
        begin
            mem[q_entry.waddr] <= q_entry.wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign word_a = rect_reg.ok[hfe_pkg::CORNER_A] ? rdata0_reg : '0;
    assign word_d = rect_reg.ok[hfe_pkg::CORNER_D] ? rdata1_reg : '0;
    assign word_b = rect_reg.ok[hfe_pkg::CORNER_B] ? rdata0_reg : '0;
    assign word_c = rect_reg.ok[hfe_pkg::CORNER_C] ? rdata1_reg : '0;

    assign rect_val  = hfe_pkg::TOTAL_W'(pos_sum_reg) - hfe_pkg::TOTAL_W'(word_b)
                       - hfe_pkg::TOTAL_W'(word_c);
    assign black_upd = rect_reg.is_black ? black_total_reg + rect_val : black_total_reg;
    assign white_upd = rect_reg.is_black ? white_total_reg : white_total_reg + rect_val;

    // |black - white| on 41 bits, saturated to the output width; an oversize feature gives OVERSIZE_VALUE instead
    always_comb
    begin
        if ($signed(fin_black_reg) >= $signed(fin_white_reg))
        begin
            mag = {fin_black_reg[hfe_pkg::TOTAL_W-1], fin_black_reg}
                - {fin_white_reg[hfe_pkg::TOTAL_W-1], fin_white_reg};
        end
        else
        begin
            mag = {fin_white_reg[hfe_pkg::TOTAL_W-1], fin_white_reg}
                - {fin_black_reg[hfe_pkg::TOTAL_W-1], fin_black_reg};
        end
        if (fin_oversize_reg)
        begin
            result_value = hfe_pkg::OVERSIZE_VALUE;
        end
        else if (|mag[hfe_pkg::TOTAL_W:hfe_pkg::OUT_W])
        begin
            result_value = '1;
        end
        else
        begin
            result_value = mag[hfe_pkg::OUT_W-1:0];
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        oversize_flag_next = oversize_flag_reg;
        black_total_next   = black_total_reg;
        white_total_next   = white_total_reg;
        fin_valid_next     = fin_valid_reg && !fin_drain;
        out_valid_next     = out_valid_reg && out_stall;
        if (fin_drain)
        begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_rect)
                begin
                    state_next = ST_SECOND;
                end
            end
            ST_SECOND:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (acc_go)
                begin
                    state_next = pop_rect ? ST_SECOND : ST_IDLE;
                    if (rect_reg.last)
                    begin
                        black_total_next = '0;
                        white_total_next = '0;
                        fin_valid_next   = 1'b1;
                    end
                    else
                    begin
                        black_total_next = black_upd;
                        white_total_next = white_upd;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // a header after the rectangle in ACC wins
        if (pop_header)
        begin
            oversize_flag_next = q_entry.oversize;
            black_total_next   = '0;
            white_total_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            oversize_flag_reg <= 1'b0;
            black_total_reg   <= '0;
            white_total_reg   <= '0;
            fin_valid_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            oversize_flag_reg <= oversize_flag_next;
            black_total_reg   <= black_total_next;
            white_total_reg   <= white_total_next;
            fin_valid_reg     <= fin_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            raddr0_reg <= raddr0;
            raddr1_reg <= raddr1;
        end
        if (pop_rect)
        begin
            rect_reg <= q_entry;
        end
        if (in_second)
        begin
            pos_sum_reg <= {1'b0, word_a} + {1'b0, word_d};
        end
        if (acc_update && rect_reg.last)
        begin
            fin_black_reg    <= black_upd;
            fin_white_reg    <= white_upd;
            fin_oversize_reg <= oversize_flag_reg;
        end
        if (fin_drain)
        begin
            filter_value_reg   <= result_value;
            mask_too_large_reg <= fin_oversize_reg;
        end
    end

endmodule
`default_nettype wire

### hdl/haar_feature_evaluator.sv
// Top level of the Haar feature evaluator: front end, item queue and back end.
//
// Evaluates Haar-like features on a 24 x 24 integral image held in an internal
// dual-port memory. Each rectangle's four corner reads share the memory's two
// read ports, A and D first, then B and C. A two-entry queue sits between the
// item decoder and the back end, so items are accepted while the back end works
// or a result waits, until the queue is full. The result of a last rectangle is
// registered in turn in the corner read and rectangle registers, the partial sum,
// the finished totals and the output register, provided that register is free.
// Store entries read before they were loaded give undefined sums. Configuration
// writes are taken on any cycle but must only happen idle.
`default_nettype none
module haar_feature_evaluator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write_en,
    input  wire logic [hfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [hfe_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         req_type,
    input  wire logic [hfe_pkg::FIELD_W-1:0]        pos_x,
    input  wire logic [hfe_pkg::FIELD_W-1:0]        pos_y,
    input  wire logic [hfe_pkg::FIELD_W-1:0]        mask_w,
    input  wire logic [hfe_pkg::FIELD_W-1:0]        mask_h,
    input  wire logic [hfe_pkg::WORD_W-1:0]         word_value,
    input  wire logic                               is_black,
    input  wire logic                               last_rect,
    input  wire logic [hfe_pkg::CORNER_W-1:0]       corner_a,
    input  wire logic [hfe_pkg::CORNER_W-1:0]       corner_b,
    input  wire logic [hfe_pkg::CORNER_W-1:0]       corner_c,
    input  wire logic [hfe_pkg::CORNER_W-1:0]       corner_d,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [hfe_pkg::OUT_W-1:0]               filter_value,
    output logic                                    mask_too_large
);

    logic               q_full;
    logic               push;
    hfe_pkg::entry_t    push_entry;
    logic               q_pop;
    logic               q_valid;
    hfe_pkg::entry_t    q_entry;

    hfe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .mask_w       (mask_w),
        .mask_h       (mask_h),
        .word_value   (word_value),
        .is_black     (is_black),
        .last_rect    (last_rect),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .corner_d     (corner_d),
        .q_full       (q_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    hfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    hfe_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_entry        (q_entry),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filter_value   (filter_value),
        .mask_too_large (mask_too_large)
    );

endmodule
`default_nettype wire

### bench/haar_feature_evaluator_tb.sv
// Self-checking testbench for the Haar feature evaluator: directed features, then random phases.
module haar_feature_evaluator_tb;

    import hfe_pkg::*;

    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          PHASE_ITEMS  = 200;
    localparam logic [63:0] FILTER_MAX   = 64'hF_FFFF_FFFF;
    localparam int          MAX_REPORTS  = 40;

    typedef struct {
        logic [1:0]          req;
        logic [FIELD_W-1:0]  px;
        logic [FIELD_W-1:0]  py;
        logic [FIELD_W-1:0]  mw;
        logic [FIELD_W-1:0]  mh;
        logic [WORD_W-1:0]   word;
        logic                blk;
        logic                last;
        logic [CORNER_W-1:0] corner [NUM_CORNERS];
    } haar_item_t;

    typedef struct {
        logic [OUT_W-1:0] value;
        logic             flag;
    } filter_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             req_type = '0;
    logic [FIELD_W-1:0]     pos_x = '0;
    logic [FIELD_W-1:0]     pos_y = '0;
    logic [FIELD_W-1:0]     mask_w = '0;
    logic [FIELD_W-1:0]     mask_h = '0;
    logic [WORD_W-1:0]      word_value = '0;
    logic                   is_black = 1'b0;
    logic                   last_rect = 1'b0;
    logic [CORNER_W-1:0]    corner_a = '0;
    logic [CORNER_W-1:0]    corner_b = '0;
    logic [CORNER_W-1:0]    corner_c = '0;
    logic [CORNER_W-1:0]    corner_d = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [OUT_W-1:0]       filter_value;
    logic                   mask_too_large;

    // predictor state
    logic [WORD_W-1:0]  integral_img [IMAGE_SIDE*IMAGE_SIDE];
    bit                 img_loaded [IMAGE_SIDE*IMAGE_SIDE];
    int                 cur_width = 24;
    int                 cur_height = 24;
    int                 latched_px = 0;
    int                 latched_py = 0;
    bit                 latched_oversize = 1'b0;
    logic [TOTAL_W-1:0] black_sum = '0;
    logic [TOTAL_W-1:0] white_sum = '0;
    filter_result_t     expected_filters [$];

    int mismatches = 0;
    int results_seen = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int hold_count = 0;
    int stall_len;
    bit no_idle = 1'b0;
    filter_result_t want;

    haar_feature_evaluator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .mask_w         (mask_w),
        .mask_h         (mask_h),
        .word_value     (word_value),
        .is_black       (is_black),
        .last_rect      (last_rect),
        .corner_a       (corner_a),
        .corner_b       (corner_b),
        .corner_c       (corner_c),
        .corner_d       (corner_d),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filter_value   (filter_value),
        .mask_too_large (mask_too_large)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit point_inside(int x, int y);
        int wl;
        int hl;
        wl = (cur_width < IMAGE_SIDE) ? cur_width : IMAGE_SIDE;
        hl = (cur_height < IMAGE_SIDE) ? cur_height : IMAGE_SIDE;
        return x >= 0 && y >= 0 && x < wl && y < hl;
    endfunction

    function automatic longint sample_point(int x, int y);
        if (!point_inside(x, y))
            return 0;
        return longint'(integral_img[y*IMAGE_SIDE + x]);
    endfunction

    // A sits up-left, B up, C left of its given point; D is taken as is
    function automatic void corner_point(int k, logic [CORNER_W-1:0] c, output int x,
                                         output int y);
        x = int'(c[4:0]) + latched_px - ((k == CORNER_A || k == CORNER_C) ? 1 : 0);
        y = int'(c[9:5]) + latched_py - ((k == CORNER_A || k == CORNER_B) ? 1 : 0);
    endfunction

    function automatic void evaluate_item(haar_item_t it);
        longint         rect;
        longint         b;
        longint         w;
        longint         diff;
        int             x;
        int             y;
        filter_result_t res;
        case (it.req)
            REQ_LOAD:
            begin
                if (int'(it.px) < IMAGE_SIDE && int'(it.py) < IMAGE_SIDE)
                begin
                    integral_img[int'(it.py)*IMAGE_SIDE + int'(it.px)] = it.word;
                    img_loaded[int'(it.py)*IMAGE_SIDE + int'(it.px)] = 1'b1;
                end
            end
            REQ_HEADER:
            begin
                latched_px = int'(it.px);
                latched_py = int'(it.py);
                latched_oversize = int'(it.mw) > cur_width || int'(it.mh) > cur_height;
                black_sum = '0;
                white_sum = '0;
            end
            REQ_RECT:
            begin
                rect = 0;
                for (int k = 0; k < NUM_CORNERS; k++)
                begin
                    corner_point(k, it.corner[k], x, y);
                    if (k == CORNER_A || k == CORNER_D)
                        rect += sample_point(x, y);
                    else
                        rect -= sample_point(x, y);
                end
                if (it.blk)
                    black_sum = black_sum + rect[TOTAL_W-1:0];
                else
                    white_sum = white_sum + rect[TOTAL_W-1:0];
                if (it.last)
                begin
                    if (latched_oversize)
                        res.value = OVERSIZE_VALUE;
                    else
                    begin
                        b = $signed(black_sum);
                        w = $signed(white_sum);
                        diff = b - w;
                        if (diff < 0)
                            diff = -diff;
                        res.value = (diff > FILTER_MAX) ? FILTER_MAX[OUT_W-1:0]
                                                        : diff[OUT_W-1:0];
                    end
                    res.flag = latched_oversize;
                    expected_filters.push_back(res);
                    black_sum = '0;
                    white_sum = '0;
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- item builders

    function automatic logic [CORNER_W-1:0] pt(int x, int y);
        return {5'(y), 5'(x)};
    endfunction

    function automatic haar_item_t noise_item();
        haar_item_t it;
        it.req  = 2'($urandom);
        it.px   = 5'($urandom);
        it.py   = 5'($urandom);
        it.mw   = 5'($urandom);
        it.mh   = 5'($urandom);
        it.word = $urandom;
        it.blk  = 1'($urandom);
        it.last = 1'($urandom);
        for (int k = 0; k < NUM_CORNERS; k++)
            it.corner[k] = 10'($urandom);
        return it;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic haar_item_t make_load(int x, int y, logic [WORD_W-1:0] w);
        haar_item_t it;
        it = noise_item();
        it.req  = REQ_LOAD;
        it.px   = 5'(x);
        it.py   = 5'(y);
        it.word = w;
        return it;
    endfunction

    function automatic haar_item_t make_header(int x, int y, int mw, int mh);
        haar_item_t it;
        it = noise_item();
        it.req = REQ_HEADER;
        it.px  = 5'(x);
        it.py  = 5'(y);
        it.mw  = 5'(mw);
        it.mh  = 5'(mh);
        return it;
    endfunction

    function automatic haar_item_t make_rect(logic [CORNER_W-1:0] a, logic [CORNER_W-1:0] b,
                                             logic [CORNER_W-1:0] c, logic [CORNER_W-1:0] d,
                                             bit blk, bit last);
        haar_item_t it;
        it = noise_item();
        it.req = REQ_RECT;
        it.corner[CORNER_A] = a;
        it.corner[CORNER_B] = b;
        it.corner[CORNER_C] = c;
        it.corner[CORNER_D] = d;
        it.blk  = blk;
        it.last = last;
        return it;
    endfunction

    // mostly lands near the image in use, sometimes anywhere in the field
    function automatic int rand_coord(int dim);
        int lim;
        lim = (dim < IMAGE_SIDE) ? dim : IMAGE_SIDE;
        if ($urandom_range(0, 4) != 0)
            return $urandom_range(0, lim);
        return $urandom_range(0, 31);
    endfunction

    function automatic int rand_mask(int dim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, (dim < 31) ? dim : 31);
        if (r < 75)
            return (dim + int'($urandom_range(0, 1)) > 31) ? 31 : dim + $urandom_range(0, 1);
        return $urandom_range(0, 31);
    endfunction

    function automatic haar_item_t rand_header();
        int x;
        int y;
        if ($urandom_range(0, 4) != 0)
        begin
            x = $urandom_range(0, (cur_width > 1) ? cur_width / 2 : 0);
            y = $urandom_range(0, (cur_height > 1) ? cur_height / 2 : 0);
        end
        else
        begin
            x = $urandom_range(0, 31);
            y = $urandom_range(0, 31);
        end
        return make_header(x, y, rand_mask(cur_width), rand_mask(cur_height));
    endfunction

    function automatic haar_item_t rand_rect(bit blk, bit last);
        return make_rect(pt(rand_coord(cur_width), rand_coord(cur_height)),
                         pt(rand_coord(cur_width), rand_coord(cur_height)),
                         pt(rand_coord(cur_width), rand_coord(cur_height)),
                         pt(rand_coord(cur_width), rand_coord(cur_height)), blk, last);
    endfunction

    // ---------------------------------------------------------------- driving

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic send_item(haar_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= it.req;
        pos_x      <= it.px;
        pos_y      <= it.py;
        mask_w     <= it.mw;
        mask_h     <= it.mh;
        word_value <= it.word;
        is_black   <= it.blk;
        last_rect  <= it.last;
        corner_a   <= it.corner[CORNER_A];
        corner_b   <= it.corner[CORNER_B];
        corner_c   <= it.corner[CORNER_C];
        corner_d   <= it.corner[CORNER_D];
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        evaluate_item(it);
        if (!(it.req == REQ_UNUSED ||
              (it.req == REQ_LOAD && (int'(it.px) >= IMAGE_SIDE || int'(it.py) >= IMAGE_SIDE))))
            items_sent++;
    endtask

    // loads any in-image corner the store has not seen yet, then sends the rectangle
    task automatic send_rect(haar_item_t it);
        int x;
        int y;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            corner_point(k, it.corner[k], x, y);
            if (point_inside(x, y) && !img_loaded[y*IMAGE_SIDE + x])
                send_item(make_load(x, y, rand_word()));
        end
        send_item(it);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_filters.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(int w, int h);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_IMAGE_WIDTH;
        cfg_data     <= 5'(w);
        @(posedge clk);
        cur_width = w;
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= 5'(h);
        @(posedge clk);
        cur_height = h;
        cfg_write_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------- result check

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on result %0d: %s got %0h, want %0h",
                     results_seen, what, got, exp_val);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            results_seen++;
            if (expected_filters.size() == 0)
                report_mismatch("unexpected item, filter_value", 64'(filter_value), 64'd0);
            else
            begin
                want = expected_filters.pop_front();
                if (filter_value !== want.value)
                    report_mismatch("filter_value", 64'(filter_value), 64'(want.value));
                if (mask_too_large !== want.flag)
                    report_mismatch("mask_too_large", 64'(mask_too_large), 64'(want.flag));
            end
        end
        if (hold_count > 0)
            hold_count--;
        else if (out_stall)
        begin
            out_stall <= 1'b0;
            hold_count = $urandom_range(0, 8);
        end
        else
        begin
            stall_len = pick_gap();
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                hold_count = stall_len - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("haar_feature_evaluator regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // placement and flag still hold their reset values
    task automatic test_headerless_rect();
        send_rect(make_rect(pt(1, 1), pt(3, 0), pt(0, 2), pt(5, 5), 1'b1, 1'b1));
    endtask

    task automatic test_extremes();
        haar_item_t it;
        send_item(make_load(23, 23, '1));
        send_item(make_load(0, 0, '0));
        send_item(make_load(31, 31, $urandom));
        it = noise_item();
        it.req = REQ_UNUSED;
        send_item(it);
        // full-size mask; A and D both hit the far corner, B and C fall outside
        send_item(make_header(0, 0, 24, 24));
        send_rect(make_rect(pt(24, 24), pt(0, 0), pt(0, 0), pt(23, 23), 1'b1, 1'b1));
        send_item(make_header(0, 0, 25, 0));
        send_rect(make_rect(pt(0, 0), pt(0, 0), pt(0, 0), pt(0, 0), 1'b0, 1'b1));
        // placement at the far end puts every corner outside
        send_item(make_header(31, 31, 0, 0));
        send_rect(make_rect(pt(31, 31), pt(31, 31), pt(31, 31), pt(31, 31), 1'b1, 1'b1));
        send_item(make_header(3, 3, 24, 25));
        send_rect(make_rect(pt(0, 0), pt(2, 1), pt(1, 2), pt(4, 4), 1'b0, 1'b1));
    endtask

    // nine maximal black rectangles push the difference past the output range
    task automatic test_saturation();
        send_item(make_header(0, 0, 0, 0));
        send_item(make_load(0, 0, '1));
        for (int i = 0; i < 9; i++)
            send_rect(make_rect(pt(1, 1), pt(0, 0), pt(0, 0), pt(0, 0), 1'b1, i == 8));
    endtask

    task automatic run_random(int count);
        int  goal;
        int  r;
        int  n;
        bit  heavy_side;
        haar_item_t it;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 11) == 0)
                no_idle = !no_idle;
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_item(make_load($urandom_range(0, 9) == 0 ? $urandom_range(24, 31)
                                                                  : $urandom_range(0, 23),
                                        $urandom_range(0, 23), rand_word()));
            end
            else if (r < 78)
            begin
                send_item(rand_header());
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_rect(rand_rect(1'($urandom), i == n - 1));
            end
            else if (r < 79)
            begin
                // long feature of maximal rectangles: the totals wrap around
                send_item(make_load(0, 0, '1));
                send_item(make_header(0, 0, $urandom_range(0, 31), $urandom_range(0, 31)));
                heavy_side = 1'($urandom);
                n = $urandom_range(130, 160);
                for (int i = 0; i < n; i++)
                    send_rect(make_rect(pt(1, 1), pt(0, 0), pt(0, 0), pt(0, 0),
                                        ($urandom_range(0, 9) == 0) ? !heavy_side : heavy_side,
                                        i == n - 1));
            end
            else if (r < 87)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    send_rect(rand_rect(1'($urandom), 1'($urandom)));
            end
            else if (r < 93)
            begin
                // feature abandoned before its last rectangle
                send_item(rand_header());
                n = $urandom_range(0, 3);
                repeat (n)
                    send_rect(rand_rect(1'($urandom), 1'b0));
            end
            else
            begin
                it = noise_item();
                if ($urandom_range(0, 1) == 0)
                    it.req = REQ_UNUSED;
                else
                    it = make_load($urandom_range(24, 31), $urandom_range(0, 31), $urandom);
                send_item(it);
            end
        end
    endtask

    task automatic test_random_phases();
        int widths [8];
        int heights [8];
        int w;
        int h;
        widths  = '{24, 31, 1, 0, 12, 24, 0, 0};
        heights = '{24, 31, 1, 17, 7, 1, 0, 0};
        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            w = (p >= 6) ? $urandom_range(0, 31) : widths[p];
            h = (p >= 6) ? $urandom_range(0, 31) : heights[p];
            write_size(w, h);
            no_idle = ($urandom_range(0, 3) == 0);
            run_random(PHASE_ITEMS);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_headerless_rect();
        test_extremes();
        test_saturation();
        test_random_phases();
        wait_idle();
        if (mismatches == 0)
            $display("haar_feature_evaluator regression: pass");
        else
            $display("haar_feature_evaluator regression: fail");
        $finish;
    end

endmodule
